// ===== rtl/lbfr_pkg.sv =====
// Shared types, constants and helpers for the LED blink and flash renderer.
package lbfr_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int TIME_W     = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_BRIGHTNESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_INVERTED     = 2'd1;

   localparam logic [7:0]  FULL_SCALE        = 8'd255;
   localparam logic [7:0]  DEFAULT_BRIGHT_RST = 8'd255;
   localparam logic [23:0] SHOWN_COLOR_RST    = 24'h010101;

   typedef enum logic {
      OP_RENDER = 1'b0,
      OP_FLASH  = 1'b1
   } op_type;

   // time_ms holds now for a render request, the end time for a flash request
   typedef struct packed {
      op_type            op;
      logic [TIME_W-1:0] time_ms;
      logic [23:0]       color;
      logic [15:0]       period;
      logic [7:0]        brightness;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_out_type;

   typedef struct packed {
      logic [7:0] default_brightness;
      logic       drive_inverted;
   } cfg_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

   // exact x / 255 for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'(x >> 8) + 17'd1;
      return t[15:8];
   endfunction

endpackage

// ===== rtl/lbfr_req_if.sv =====
// Request channel: valid/ready handshake with the render and flash fields.
interface lbfr_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] now_ms;
   logic [7:0]  color_red;
   logic [7:0]  color_green;
   logic [7:0]  color_blue;
   logic [15:0] blink_period;
   logic [7:0]  pattern_brightness;
   logic [15:0] flash_duration_ms;

   modport source (
      output valid, kind, now_ms, color_red, color_green, color_blue,
             blink_period, pattern_brightness, flash_duration_ms,
      input  ready
   );
   modport sink (
      input  valid, kind, now_ms, color_red, color_green, color_blue,
             blink_period, pattern_brightness, flash_duration_ms,
      output ready
   );
endinterface

// ===== rtl/lbfr_rsp_if.sv =====
// Response channel: valid/ready handshake with the three drive levels.
interface lbfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] drive_red;
   logic [7:0] drive_green;
   logic [7:0] drive_blue;

   modport source (
      output valid, drive_red, drive_green, drive_blue,
      input  ready
   );
   modport sink (
      input  valid, drive_red, drive_green, drive_blue,
      output ready
   );
endinterface

// ===== rtl/lbfr_queue.sv =====
// Front end: accepts requests, classifies them and queues them for the engine.
module lbfr_queue
   import lbfr_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   lbfr_req_if.sink  req,
   input  logic      q_pop,
   output q_out_type q_out
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   entry_type        new_entry;

   assign req.ready = (count_ff != CNT_W'(DEPTH));
   assign push      = req.valid && req.ready;

   // a flash carries its end time instead of now
   always_comb begin
      new_entry.op         = req.kind ? OP_FLASH : OP_RENDER;
      new_entry.time_ms    = req.kind ? req.now_ms + TIME_W'(req.flash_duration_ms)
                                      : req.now_ms;
      new_entry.color      = {req.color_red, req.color_green, req.color_blue};
      new_entry.period     = req.blink_period;
      new_entry.brightness = req.pattern_brightness;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.entry = mem_ff[rd_ptr_ff];

endmodule

// ===== rtl/lbfr_rem.sv =====
// Bit-serial restoring remainder of the time by the blink period.
module lbfr_rem
   import lbfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [15:0]       divisor,
   output logic              done,
   output logic [15:0]       remainder
);

   localparam int CNT_W = $clog2(TIME_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] dividend_ff, dividend_in;
   logic [15:0]       divisor_ff, divisor_in;
   logic [15:0]       rem_ff, rem_in;
   logic [16:0]       trial;
   logic [16:0]       diff;

   assign trial = {rem_ff, dividend_ff[TIME_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (start) begin
         busy_in     = 1'b1;
         count_in    = CNT_W'(TIME_W - 1);
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[TIME_W-2:0], 1'b0};
         rem_in      = (trial >= {1'b0, divisor_ff}) ? diff[15:0] : trial[15:0];
         count_in    = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff    <= count_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/lbfr_back.sv =====
// Back end: flash state, blink phase, write cache, scaling and response register.
module lbfr_back
   import lbfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  q_out_type       q_out,
   output logic            q_pop,
   output back_status_type status,
   lbfr_rsp_if.source      rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCALE
   } state_type;

   state_type         state_ff, state_in;
   entry_type         item_ff, item_in;
   logic              flash_active_ff, flash_active_in;
   logic [23:0]       flash_color_ff, flash_color_in;
   logic [TIME_W-1:0] flash_end_ff, flash_end_in;
   logic [23:0]       shown_color_ff, shown_color_in;
   logic [7:0]        shown_bright_ff, shown_bright_in;
   logic              primed_ff, primed_in;
   logic [15:0]       prod_r_ff, prod_r_in;
   logic [15:0]       prod_g_ff, prod_g_in;
   logic [15:0]       prod_b_ff, prod_b_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_red_ff, rsp_red_in;
   logic [7:0]        rsp_green_ff, rsp_green_in;
   logic [7:0]        rsp_blue_ff, rsp_blue_in;

   logic              rem_start;
   logic              rem_done;
   logic [15:0]       rem_value;
   logic [TIME_W-1:0] diff;
   logic              flash_shown;
   logic              flash_ends;
   logic              lit;
   logic [23:0]       want;
   logic [7:0]        bright;
   logic [7:0]        scale_b;
   logic              emit;
   logic              out_ready;
   logic [7:0]        lvl_r, lvl_g, lvl_b;

   assign q_pop     = (state_ff == ST_IDLE) && q_out.valid;
   assign rem_start = q_pop && (q_out.entry.op == OP_RENDER);

   lbfr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (q_out.entry.time_ms),
      .divisor   (q_out.entry.period),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // flash runs while the signed difference to its end time is negative
   assign diff        = item_ff.time_ms - flash_end_ff;
   assign flash_shown = flash_active_ff && diff[TIME_W-1];
   assign flash_ends  = flash_active_ff && !diff[TIME_W-1];
   assign lit         = (item_ff.period == '0) || (rem_value < (item_ff.period >> 1));
   assign want        = flash_shown ? flash_color_ff : (lit ? item_ff.color : '0);
   assign bright      = flash_shown ? 8'd0 : item_ff.brightness;
   assign scale_b     = (bright != 8'd0) ? bright : cfg.default_brightness;
   assign emit        = !(primed_ff && (want == shown_color_ff)
                          && (bright == shown_bright_ff));
   assign out_ready   = !rsp_valid_ff || rsp.ready;

   assign lvl_r = div255(prod_r_ff);
   assign lvl_g = div255(prod_g_ff);
   assign lvl_b = div255(prod_b_ff);

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      flash_active_in = flash_active_ff;
      flash_color_in  = flash_color_ff;
      flash_end_in    = flash_end_ff;
      shown_color_in  = shown_color_ff;
      shown_bright_in = shown_bright_ff;
      primed_in       = primed_ff;
      prod_r_in       = prod_r_ff;
      prod_g_in       = prod_g_ff;
      prod_b_in       = prod_b_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_red_in      = rsp_red_ff;
      rsp_green_in    = rsp_green_ff;
      rsp_blue_in     = rsp_blue_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_out.entry.op == OP_FLASH) begin
                  flash_active_in = 1'b1;
                  flash_color_in  = q_out.entry.color;
                  flash_end_in    = q_out.entry.time_ms;
               end else begin
                  item_in  = q_out.entry;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               if (flash_ends) begin
                  flash_active_in = 1'b0;
               end
               if (emit) begin
                  shown_color_in  = want;
                  shown_bright_in = bright;
                  primed_in       = 1'b1;
                  prod_r_in       = 16'(want[23:16]) * 16'(scale_b);
                  prod_g_in       = 16'(want[15:8]) * 16'(scale_b);
                  prod_b_in       = 16'(want[7:0]) * 16'(scale_b);
                  state_in        = ST_SCALE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCALE: begin
            if (out_ready) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = cfg.drive_inverted ? FULL_SCALE - lvl_r : lvl_r;
               rsp_green_in = cfg.drive_inverted ? FULL_SCALE - lvl_g : lvl_g;
               rsp_blue_in  = cfg.drive_inverted ? FULL_SCALE - lvl_b : lvl_b;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         flash_active_ff <= 1'b0;
         flash_color_ff  <= '0;
         flash_end_ff    <= '0;
         shown_color_ff  <= SHOWN_COLOR_RST;
         shown_bright_ff <= '0;
         primed_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         flash_active_ff <= flash_active_in;
         flash_color_ff  <= flash_color_in;
         flash_end_ff    <= flash_end_in;
         shown_color_ff  <= shown_color_in;
         shown_bright_ff <= shown_bright_in;
         primed_ff       <= primed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      item_ff      <= item_in;
      prod_r_ff    <= prod_r_in;
      prod_g_ff    <= prod_g_in;
      prod_b_ff    <= prod_b_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
   end

   assign status.busy     = (state_ff != ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.drive_red   = rsp_red_ff;
   assign rsp.drive_green = rsp_green_ff;
   assign rsp.drive_blue  = rsp_blue_ff;

endmodule

// ===== rtl/led_blink_flash_renderer_top.sv =====
// RGB indicator lamp engine: render and flash requests in, drive levels out.
//
// req_chan takes requests with valid/ready. kind 1 arms a one-shot flash and
// never gives a response; kind 0 is a render tick that gives a response only
// when the shown colour or raw brightness changes, or for the first tick after reset.
// rsp_chan carries the scaled (and optionally inverted) drive levels.
// csr_*: write default_brightness (index 0) or drive_inverted (index 1);
// other indexes are dropped. Write only while the block is idle.
//
// Requests enter a QUEUE_DEPTH-entry queue, so req_chan.ready stays high
// until the queue fills. A render tick runs in the engine through the
// 32-step serial remainder of now_ms by the blink period, then through the
// scaling state only when it gives a response. A flash request is popped
// only while the engine is idle and leaves it idle.
// The response sits in an output register; while rsp_chan stalls the engine
// holds its finished result and the queue keeps taking requests until it fills.
// Synchronous reset clears the queue, the flash state and the write cache;
// default_brightness returns to 255 and drive_inverted to 0.
module led_blink_flash_renderer_top
   import lbfr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   lbfr_req_if.sink              req_chan,
   lbfr_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   q_out_type       q_out;
   logic            q_pop;
   back_status_type back_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEFAULT_BRIGHTNESS: cfg_in.default_brightness = csr_wdata[7:0];
            CSR_DRIVE_INVERTED:     cfg_in.drive_inverted     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_brightness <= DEFAULT_BRIGHT_RST;
         cfg_ff.drive_inverted     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lbfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .q_pop (q_pop),
      .q_out (q_out)
   );

   lbfr_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_out  (q_out),
      .q_pop  (q_pop),
      .status (back_status),
      .rsp    (rsp_chan)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_out.valid)
      else $error("engine popped an empty queue");

   a_full_means_entries: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> q_out.valid)
      else $error("request stalled while queue is empty");

   a_rsp_from_busy_engine: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(back_status.busy))
      else $error("response raised by an idle engine");

endmodule
